// ===== design/twss_pkg.sv =====
// ----------------------------------------------------------------------------
// twss_pkg: shared types and constants
// Field widths, register indexes and the descriptor passed from the front
// end to the divider back end of the wall span setup block.
// ----------------------------------------------------------------------------
package twss_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int MAX_SCREEN_ROWS = 4096;
   localparam int MAX_TEX_SIZE    = 1024;

   localparam int COL_W   = 12;
   localparam int DIST_W  = 24;
   localparam int DIR_W   = 21;
   localparam int POS_W   = 24;
   localparam int SH_W    = 13;
   localparam int TEX_W   = 11;
   localparam int ROW_W   = 12;
   localparam int TXC_W   = 10;
   localparam int STEP_W  = 26;
   localparam int START_W = 27;
   localparam int LINE_W  = 16;

   // Dividend widths for the two divisions.
   localparam int NUM_W   = SH_W + FRAC_BITS;     // 29
   localparam int CNT_W   = 5;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 104;

   localparam int REG_IDX_W = 2;
   typedef enum logic [REG_IDX_W-1:0] {
      REG_SCREEN_HEIGHT = 2'd0,
      REG_TEX_WIDTH     = 2'd1,
      REG_TEX_HEIGHT    = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      TEX_NORTH = 2'd0,
      TEX_SOUTH = 2'd1,
      TEX_WEST  = 2'd2,
      TEX_EAST  = 2'd3
   } tex_id_type;

   typedef enum logic [1:0] {
      DIV_IDLE = 2'd0,
      DIV_LINE = 2'd1,
      DIV_STEP = 2'd2,
      DIV_DONE = 2'd3
   } div_state_type;

   // Classified column handed to the back end.
   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [DIST_W-1:0] wall_dist;
      logic [SH_W-1:0]   height;
      logic [TEX_W-1:0]  tex_h;
      tex_id_type        tex_id;
      logic [TXC_W-1:0]  texel_column;
   } desc_type;

endpackage

// ===== design/twss_front.sv =====
// ----------------------------------------------------------------------------
// twss_front: request classifier
// Picks the texture, computes the hit point fraction and the mirrored texel
// column in two registered stages, then pushes a descriptor to the queue.
// ----------------------------------------------------------------------------
module twss_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [twss_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [twss_pkg::SH_W-1:0]        height,
   input  logic [twss_pkg::TEX_W-1:0]       tex_w,
   input  logic [twss_pkg::TEX_W-1:0]       tex_h,
   output logic                             push,
   output twss_pkg::desc_type               push_desc,
   input  logic                             queue_ready
);
   import twss_pkg::*;

   localparam int PROD_W = DIST_W + DIR_W;         // 45, signed product
   localparam int FR_W   = 2 * FRAC_BITS;          // 32

   // Stage one registers.
   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_col_ff;
   logic [DIST_W-1:0] s1_dist_ff;
   logic             s1_mirror_ff;
   tex_id_type       s1_id_ff;
   logic [FR_W-1:0]  s1_frac_ff;

   // Stage two registers.
   logic             s2_valid_ff, s2_valid_in;
   desc_type         s2_desc_ff;

   logic             adv1, adv2;
   logic [COL_W-1:0] col;
   logic [DIST_W-1:0] wall_dist;
   logic             side;
   logic signed [DIR_W-1:0] dx, dy, dsel;
   logic [POS_W-1:0] px, py, psel;
   logic             dx_pos, dy_pos, dy_neg, mirror;
   tex_id_type       id;
   logic signed [PROD_W:0] prod;
   logic [FR_W-1:0]  frac;
   logic [FR_W+TEX_W-1:0] fw;
   logic [TEX_W-1:0] tx_raw, tx_cl, tx_fin;

   assign col       = req_tdata[11:0];
   assign wall_dist = req_tdata[35:12];
   assign side      = req_tdata[36];
   assign dx        = req_tdata[57:37];
   assign dy        = req_tdata[78:58];
   assign px        = req_tdata[102:79];
   assign py        = req_tdata[126:103];

   // Pipeline advance: the last stage drains into the queue.
   assign adv2 = !s2_valid_ff || queue_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_tready = adv1;
   assign push = s2_valid_ff && queue_ready;
   assign push_desc = s2_desc_ff;

   // Texture choice and the hit point product.
   always_comb begin
      dx_pos = !dx[DIR_W-1] && (dx != '0);
      dy_pos = !dy[DIR_W-1] && (dy != '0);
      dy_neg = dy[DIR_W-1];
      if (!side) begin
         id     = dx_pos ? TEX_WEST : TEX_EAST;
         mirror = dx_pos;
         dsel   = dy;
         psel   = py;
      end else begin
         id     = dy_pos ? TEX_SOUTH : TEX_NORTH;
         mirror = dy_neg;
         dsel   = dx;
         psel   = px;
      end
      prod = $signed({1'b0, wall_dist}) * dsel;
      frac = FR_W'({psel, {FRAC_BITS{1'b0}}}) + prod[FR_W-1:0];
   end

   // Texel column from the fraction, clamped and mirrored.
   always_comb begin
      fw     = s1_frac_ff * tex_w;
      tx_raw = fw[FR_W+TEX_W-1:FR_W];
      tx_cl  = (tx_raw >= tex_w) ? tex_w - 1'b1 : tx_raw;
      tx_fin = s1_mirror_ff ? tex_w - 1'b1 - tx_cl : tx_cl;
   end

   assign s1_valid_in = adv1 ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_col_ff    <= col;
         s1_dist_ff   <= wall_dist;
         s1_mirror_ff <= mirror;
         s1_id_ff     <= id;
         s1_frac_ff   <= frac;
      end
      if (adv2) begin
         s2_desc_ff.column       <= s1_col_ff;
         s2_desc_ff.wall_dist    <= s1_dist_ff;
         s2_desc_ff.height       <= height;
         s2_desc_ff.tex_h        <= tex_h;
         s2_desc_ff.tex_id       <= s1_id_ff;
         s2_desc_ff.texel_column <= tx_fin[TXC_W-1:0];
      end
   end

endmodule

// ===== design/twss_queue.sv =====
// ----------------------------------------------------------------------------
// twss_queue: descriptor queue
// A two-entry first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module twss_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  twss_pkg::desc_type push_desc,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output twss_pkg::desc_type pop_desc
);
   import twss_pkg::*;

   desc_type    mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign not_full  = cnt_ff != 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_desc  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== design/twss_back.sv =====
// ----------------------------------------------------------------------------
// twss_back: span and step computation
// A radix-2 restoring divider shared by the line height and the texel step
// divisions, followed by the span clamp and the start multiplication.
// ----------------------------------------------------------------------------
module twss_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  twss_pkg::desc_type              q_desc,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [twss_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import twss_pkg::*;

   localparam logic [STEP_W-1:0]  STEP_MAX  = '1;
   localparam logic [START_W-1:0] START_MAX = '1;
   localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
   // Step dividend (T << 16) fits 27 bits; line dividend fits 29 bits.
   localparam int STEP_NUM_W = TEX_W + FRAC_BITS;

   div_state_type state_ff, state_in;
   desc_type      desc_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DIST_W:0]   rem_ff, rem_in;
   logic [DIST_W-1:0] dvsr_ff, dvsr_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [LINE_W-1:0] lh_ff, lh_in;

   logic              load;
   logic [DIST_W:0]   trial;
   logic              fits;
   logic [LINE_W-1:0] lh_sat;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic              out_free;

   // Span and start terms.
   logic [ROW_W:0]    half_h, half_l, first, last;
   logic [LINE_W:0]   last_sum;
   logic [LINE_W-1:0] half_l_full;
   logic [LINE_W-1:0] offset;
   logic [NUM_W-1:0]  step_full;
   logic [STEP_W-1:0] step_sat;
   logic [LINE_W+STEP_W-1:0] start_full;
   logic [START_W-1:0] start_sat;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // One quotient bit per cycle.
   always_comb begin
      trial = {rem_ff[DIST_W-1:0], num_ff[NUM_W-1]};
      fits  = trial >= {1'b0, dvsr_ff};
   end

   always_comb begin
      if (quo_ff[NUM_W-1:LINE_W] != '0) lh_sat = LINE_MAX;
      else if (quo_ff[LINE_W-1:0] == '0) lh_sat = 16'd1;
      else lh_sat = quo_ff[LINE_W-1:0];
   end

   // Span, clamp and start for the finished column.
   always_comb begin
      half_h      = {1'b0, desc_ff.height[SH_W-1:1]};
      half_l_full = {1'b0, lh_ff[LINE_W-1:1]};
      last_sum    = {4'b0, half_h} + {1'b0, half_l_full};
      // A line taller than the screen starts part way into the texture.
      if (half_l_full > {3'b0, half_h}) begin
         first  = '0;
         offset = half_l_full - {3'b0, half_h};
      end else begin
         first  = half_h - half_l_full[ROW_W:0];
         offset = '0;
      end
      if (last_sum >= {4'b0, desc_ff.height}) last = desc_ff.height - 1'b1;
      else last = last_sum[ROW_W:0];
      half_l     = half_l_full[ROW_W:0];
      step_full  = quo_ff;
      step_sat   = (step_full > NUM_W'(STEP_MAX)) ? STEP_MAX : step_full[STEP_W-1:0];
      start_full = offset * step_full[STEP_W-1:0];
      start_sat  = (start_full > (LINE_W+STEP_W)'(START_MAX)) ? START_MAX
                   : start_full[START_W-1:0];
      out_data_in = {3'b0, start_sat, step_sat, desc_ff.texel_column,
                     desc_ff.tex_id, last[ROW_W-1:0], first[ROW_W-1:0],
                     desc_ff.column};
   end

   // Divider sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvsr_in      = dvsr_ff;
      num_in       = num_ff;
      lh_in        = lh_ff;
      load         = 1'b0;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      unique case (state_ff)
         DIV_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               load     = 1'b1;
               state_in = DIV_LINE;
               cnt_in   = CNT_W'(NUM_W - 1);
               rem_in   = '0;
               quo_in   = '0;
               num_in   = {q_desc.height, {FRAC_BITS{1'b0}}};
               dvsr_in  = q_desc.wall_dist;
            end
         end
         DIV_LINE, DIV_STEP: begin
            rem_in = fits ? trial - {1'b0, dvsr_ff} : trial;
            quo_in = {quo_ff[NUM_W-2:0], fits};
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == DIV_LINE) begin
                  // Zero distance saturates the line height.
                  lh_in = (dvsr_ff == '0) ? LINE_MAX
                        : (quo_in[NUM_W-1:LINE_W] != '0) ? LINE_MAX
                        : (quo_in[LINE_W-1:0] == '0) ? 16'd1 : quo_in[LINE_W-1:0];
                  state_in = DIV_STEP;
                  cnt_in   = CNT_W'(STEP_NUM_W - 1);
                  rem_in   = '0;
                  quo_in   = '0;
                  num_in   = {desc_ff.tex_h, {FRAC_BITS{1'b0}}, 2'b0};
                  dvsr_in  = {8'b0, lh_in};
               end else begin
                  state_in = DIV_DONE;
               end
            end
         end
         DIV_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DIV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      num_ff  <= num_in;
      lh_ff   <= lh_in;
      if (load) desc_ff <= q_desc;
      if (state_ff == DIV_DONE && out_free) out_data_ff <= out_data_in;
   end

   // The saturated quotient view and half_l are unused; they are folded into unused_ok.
   logic unused_ok;
   assign unused_ok = ^{lh_sat, half_l};

endmodule

// ===== design/textured_wall_span_setup.sv =====
// ----------------------------------------------------------------------------
// textured_wall_span_setup: wall span setup for one raycaster column
// Top level tying the classifier, descriptor queue and divider back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one ray hit per screen column; rsp_* returns one span word
//   per request, in order. csr_* writes screen height and texture sizes and
//   must be used only while no column is in flight.
//   The front end takes a new word every cycle into a two-stage pipeline while
//   the queue has room. The back end runs one shared restoring divider, one
//   quotient bit a cycle, for the line height and then the texel step, with
//   a load state before and a result state after; it takes a new column from
//   the queue only once the last one has been handed to the output register.
//   A stalled rsp_tready holds the result in the output register; the queue
//   then fills and req_tready falls. Reset empties every stage and restores
//   the registers to 480 rows and 64 by 64 texels.
// ----------------------------------------------------------------------------
module textured_wall_span_setup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // column, wall_distance, hit_side, dir_x, dir_y, player_x, player_y
   input  logic [twss_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_column, first_row, last_row, texture_id, texel_column,
   // texel_step, texel_start
   output logic [twss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [twss_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [twss_pkg::SH_W-1:0]         csr_wdata
);
   import twss_pkg::*;

   logic [SH_W-1:0]  sh_ff, sh_in;
   logic [TEX_W-1:0] tw_ff, tw_in, th_ff, th_in;
   logic [SH_W-1:0]  height;
   logic [TEX_W-1:0] tex_w, tex_h;
   logic             push, not_full, pop, not_empty;
   desc_type         push_desc, pop_desc;

   // Register writes.
   always_comb begin
      sh_in = sh_ff;
      tw_in = tw_ff;
      th_in = th_ff;
      if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_SCREEN_HEIGHT: sh_in = csr_wdata;
            REG_TEX_WIDTH:     tw_in = csr_wdata[TEX_W-1:0];
            REG_TEX_HEIGHT:    th_in = csr_wdata[TEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff <= 13'd480;
         tw_ff <= 11'd64;
         th_ff <= 11'd64;
      end else begin
         sh_ff <= sh_in;
         tw_ff <= tw_in;
         th_ff <= th_in;
      end
   end

   // Clamp the registers into their legal ranges.
   always_comb begin
      height = (sh_ff < 13'd2) ? 13'd2
             : (sh_ff > 13'(MAX_SCREEN_ROWS)) ? 13'(MAX_SCREEN_ROWS) : sh_ff;
      tex_w  = (tw_ff == '0) ? 11'd1
             : (tw_ff > 11'(MAX_TEX_SIZE)) ? 11'(MAX_TEX_SIZE) : tw_ff;
      tex_h  = (th_ff == '0) ? 11'd1
             : (th_ff > 11'(MAX_TEX_SIZE)) ? 11'(MAX_TEX_SIZE) : th_ff;
   end

   twss_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .height, .tex_w, .tex_h, .push, .push_desc,
      .queue_ready(not_full)
   );

   twss_queue u_queue (
      .clock, .reset, .push, .push_desc, .not_full,
      .pop, .not_empty, .pop_desc
   );

   twss_back u_back (
      .clock, .reset, .q_valid(not_empty), .q_desc(pop_desc), .q_pop(pop),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule

// ===== tb/textured_wall_span_setup_tb.sv =====
// ----------------------------------------------------------------------------
// textured_wall_span_setup_tb: self-checking bench for the wall span setup
// A directed table of ray hits runs first under the reset registers. Random
// hits then follow over several register settings, the extremes among them.
// Every response word is compared field by field with a table entry or a local predictor.
// Both stream sides idle at random, the receiver holds off once for a long
// stretch, and the sender drains the block once in mid-run.
// ----------------------------------------------------------------------------
module textured_wall_span_setup_tb;
   import twss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [11:0] column;
      logic [23:0] distance;
      logic        side;
      logic [20:0] dir_x;
      logic [20:0] dir_y;
      logic [23:0] pos_x;
      logic [23:0] pos_y;
   } ray_hit_type;

   typedef struct {
      logic [11:0] column;
      logic [11:0] first_row;
      logic [11:0] last_row;
      logic [1:0]  tex_id;
      logic [9:0]  texel_col;
      logic [25:0] step;
      logic [26:0] start;
   } wall_span_type;

   typedef struct {
      ray_hit_type   hit;
      bit            typed;
      wall_span_type span;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [REG_IDX_W-1:0]  csr_index = REG_SCREEN_HEIGHT;
   logic [SH_W-1:0]       csr_wdata = '0;

   // Shadow copies of the block's registers.
   logic [12:0] rows_reg  = 13'd480;
   logic [10:0] texw_reg  = 11'd64;
   logic [10:0] texh_reg  = 11'd64;

   wall_span_type span_q[$];
   int  mismatches = 0;
   int  words_in   = 0;
   int  words_out  = 0;
   bit  steady     = 1'b0;
   bit  hold_start = 1'b0;
   int  hold_left  = 0;

   textured_wall_span_setup u_dut (.*);

   always #10 clock = ~clock;

   function automatic logic [63:0] clamp64(logic [63:0] v, logic [63:0] lo,
                                           logic [63:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Expected span of one column under the current registers.
   function automatic wall_span_type predict_span(ray_hit_type h);
      logic [63:0] rows, tw, th, dx, dy, wall_dist, lh, half_h, half_l;
      logic [63:0] first, last, frac, tx, step, offset, start;
      bit          dx_pos, dy_pos, mirror;
      wall_span_type s;
      rows = clamp64(64'(rows_reg), 64'd2, 64'(MAX_SCREEN_ROWS));
      tw   = clamp64(64'(texw_reg), 64'd1, 64'(MAX_TEX_SIZE));
      th   = clamp64(64'(texh_reg), 64'd1, 64'(MAX_TEX_SIZE));
      dx   = {{43{h.dir_x[20]}}, h.dir_x};
      dy   = {{43{h.dir_y[20]}}, h.dir_y};
      wall_dist = 64'(h.distance);
      dx_pos = !dx[63] && dx != 0;
      dy_pos = !dy[63] && dy != 0;
      lh = (wall_dist == 0) ? 64'd65535
         : clamp64((rows << FRAC_BITS) / wall_dist, 64'd1, 64'd65535);
      half_h = rows >> 1;
      half_l = lh >> 1;
      first  = (half_l > half_h) ? 64'd0 : half_h - half_l;
      last   = half_h + half_l;
      if (last >= rows) last = rows - 1;
      if (!h.side) begin
         s.tex_id = dx_pos ? TEX_WEST : TEX_EAST;
         frac     = ({40'd0, h.pos_y} << FRAC_BITS) + wall_dist * dy;
         mirror   = dx_pos;
      end else begin
         s.tex_id = dy_pos ? TEX_SOUTH : TEX_NORTH;
         frac     = ({40'd0, h.pos_x} << FRAC_BITS) + wall_dist * dx;
         mirror   = dy[63];
      end
      frac = frac & 64'hFFFF_FFFF;
      tx   = (frac * tw) >> (2 * FRAC_BITS);
      if (tx >= tw) tx = tw - 1;
      if (mirror) tx = tw - 1 - tx;
      step   = (th << FRAC_BITS) / lh;
      offset = first + half_l - half_h;
      start  = offset * step;
      if (step > 64'h3FF_FFFF) step = 64'h3FF_FFFF;
      if (start > 64'h7FF_FFFF) start = 64'h7FF_FFFF;
      s.column    = h.column;
      s.first_row = first[11:0];
      s.last_row  = last[11:0];
      s.texel_col = tx[9:0];
      s.step      = step[25:0];
      s.start     = start[26:0];
      return s;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on word %0d: %s got 0x%0h, expected 0x%0h",
               words_out, field, got, want);
      mismatches++;
   endtask

   // Response checker: each accepted word against the oldest expectation.
   always @(posedge clock) begin
      wall_span_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.column    = rsp_tdata[11:0];
         got.first_row = rsp_tdata[23:12];
         got.last_row  = rsp_tdata[35:24];
         got.tex_id    = rsp_tdata[37:36];
         got.texel_col = rsp_tdata[47:38];
         got.step      = rsp_tdata[73:48];
         got.start     = rsp_tdata[100:74];
         if (span_q.size() == 0) begin
            report_mismatch("unexpected word, column", 32'(got.column), 32'd0);
         end else begin
            want = span_q.pop_front();
            if (got.column != want.column)
               report_mismatch("column", 32'(got.column), 32'(want.column));
            if (got.first_row != want.first_row)
               report_mismatch("first_row", 32'(got.first_row), 32'(want.first_row));
            if (got.last_row != want.last_row)
               report_mismatch("last_row", 32'(got.last_row), 32'(want.last_row));
            if (got.tex_id != want.tex_id)
               report_mismatch("texture_id", 32'(got.tex_id), 32'(want.tex_id));
            if (got.texel_col != want.texel_col)
               report_mismatch("texel_column", 32'(got.texel_col),
                               32'(want.texel_col));
            if (got.step != want.step)
               report_mismatch("texel_step", 32'(got.step), 32'(want.step));
            if (got.start != want.start)
               report_mismatch("texel_start", 32'(got.start), 32'(want.start));
         end
         words_out++;
      end
   end

   // Receiver: random stalls, plus one long hold-off when asked for.
   always @(negedge clock) begin
      if (hold_start) begin
         hold_left  = 400;
         hold_start = 1'b0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 34);
      end
   end

   // Offer one word and wait until it is taken.
   task automatic send_hit(ray_hit_type h, bit typed = 0,
                           wall_span_type span = '{default: 0});
      @(negedge clock);
      if (!steady && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, h.pos_y, h.pos_x, h.dir_y, h.dir_x, h.side, h.distance,
                     h.column};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (typed) span_q.push_back(span);
      else span_q.push_back(predict_span(h));
      words_in++;
   endtask

   // Stop offering and wait for every expected word, then let the divider settle.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (span_q.size() != 0) @(posedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic set_registers(logic [12:0] rows, logic [12:0] tw, logic [12:0] th);
      reg_idx_type idx;
      for (int i = 0; i < 4; i++) begin
         idx = reg_idx_type'(i);
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx;
         case (idx)
            REG_SCREEN_HEIGHT: csr_wdata <= rows;
            REG_TEX_WIDTH:     csr_wdata <= tw;
            REG_TEX_HEIGHT:    csr_wdata <= th;
            default:           csr_wdata <= 13'h1FFF;
         endcase
      end
      @(negedge clock);
      csr_we   <= 1'b0;
      rows_reg = rows;
      texw_reg = tw[10:0];
      texh_reg = th[10:0];
   endtask

   function automatic ray_hit_type random_hit();
      ray_hit_type h;
      h.column = 12'($urandom_range(4095));
      case ($urandom_range(9))
         0:       h.distance = 24'($urandom());
         1:       h.distance = 24'($urandom_range(15));
         2:       h.distance = 24'd0;
         default: h.distance = 24'($urandom_range(24'h0_2000, 24'h14_0000));
      endcase
      h.side  = 1'($urandom_range(1));
      h.dir_x = ($urandom_range(3) == 0) ? 21'($urandom())
              : 21'($signed($urandom_range(131072)) - 65536);
      h.dir_y = ($urandom_range(3) == 0) ? 21'($urandom())
              : 21'($signed($urandom_range(131072)) - 65536);
      if ($urandom_range(15) == 0) h.dir_x = '0;
      if ($urandom_range(15) == 0) h.dir_y = '0;
      h.pos_x = 24'($urandom());
      h.pos_y = 24'($urandom());
      return h;
   endfunction

   // Directed rows under the reset registers: 480 rows, 64 by 64 texels.
   table_row_type directed[] = '{
      // Distance 1.0: full-height wall, east face, hit point on a grid corner.
      '{'{12'd0, 24'h01_0000, 1'b0, 21'd0, 21'd0, 24'd0, 24'd0}, 1,
        '{12'd0, 12'd0, 12'd479, TEX_EAST, 10'd0, 26'd8738, 27'd0}},
      // Zero distance saturates the line height.
      '{'{12'd4095, 24'd0, 1'b0, 21'd0, 21'd0, 24'd0, 24'd0}, 1,
        '{12'd4095, 12'd0, 12'd479, TEX_EAST, 10'd0, 26'd64, 27'd2081728}},
      '{'{12'd1, 24'd1, 1'b0, 21'h0F_FFFF, 21'h10_0000, 24'hFF_FFFF, 24'hFF_FFFF}, 0, '{default: 0}},
      '{'{12'd2, 24'hFF_FFFF, 1'b1, 21'h10_0000, 21'h0F_FFFF, 24'hFF_FFFF, 24'hFF_FFFF}, 0, '{default: 0}},
      '{'{12'd3, 24'h02_8000, 1'b0, 21'h00_8000, 21'h1F_0000, 24'h12_3456, 24'h65_4321}, 0, '{default: 0}},
      '{'{12'd4, 24'h02_8000, 1'b0, 21'h1F_8000, 21'h00_4000, 24'h12_3456, 24'h65_4321}, 0, '{default: 0}},
      '{'{12'd5, 24'h00_C000, 1'b1, 21'h00_4000, 21'h00_C000, 24'h03_8000, 24'h00_0001}, 0, '{default: 0}},
      '{'{12'd6, 24'h00_C000, 1'b1, 21'h1F_C000, 21'h1F_4000, 24'h03_8000, 24'h00_0001}, 0, '{default: 0}},
      '{'{12'd7, 24'h00_C000, 1'b1, 21'h00_4000, 21'd0, 24'h03_FFFF, 24'd0}, 0, '{default: 0}},
      '{'{12'd8, 24'h00_0100, 1'b0, 21'h1F_FFFF, 21'h00_0001, 24'h00_FFFF, 24'h04_FFFF}, 0, '{default: 0}},
      '{'{12'd9, 24'h7F_FFFF, 1'b1, 21'h0A_AAAA, 21'h15_5555, 24'hAA_AAAA, 24'h55_5555}, 0, '{default: 0}},
      '{'{12'd10, 24'h55_5555, 1'b0, 21'h15_5555, 21'h0A_AAAA, 24'h55_5555, 24'hAA_AAAA}, 0, '{default: 0}}
   };

   // Register settings for the random phases: reset, extremes, odd sizes.
   logic [12:0] phase_cfg[8][3] = '{
      '{13'd480, 13'd64, 13'd64},     '{13'd2, 13'd1, 13'd1},
      '{13'd4096, 13'd1024, 13'd1024}, '{13'd0, 13'd0, 13'd0},
      '{13'd8191, 13'h1FFF, 13'h1FFF}, '{13'd100, 13'd7, 13'd300},
      '{13'd1, 13'd1025, 13'd2048},    '{13'd720, 13'd128, 13'd32}
   };

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_hit(directed[i].hit, directed[i].typed, directed[i].span);
      drain();

      for (int p = 0; p < 8; p++) begin
         set_registers(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
         steady = (p == 2);
         for (int n = 0; n < 205; n++) begin
            if (p == 1 && n == 20) hold_start = 1'b1;
            if (p == 3 && n == 100) drain();
            send_hit(random_hit());
         end
         drain();
      end
      steady = 1'b0;

      $display("Sent %0d columns over 8 register settings plus the reset set; %0d words checked.",
               words_in, words_out);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("timeout with %0d words outstanding", span_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
